[hdl/kmh_pkg.sv]
// Shared types and constants for the keyed min-heap counter.
// Used by the controller, the datapath and the top level; depends on nothing.
package kmh_pkg;

  // Fixed field widths.
  localparam int CNT_W = 64;
  localparam int CAP_W = 9;
  localparam int KEY_IN_W = 64;

  // Operation codes.
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic srch_start;
    logic srch_issue;
    logic take_found;
    logic take_new;
    logic rd_parent;
    logic move_parent;
    logic rd_left;
    logic eval_left;
    logic rd_right;
    logic eval_right;
    logic write_best;
    logic write_cur;
    logic rd_last;
    logic rm_load;
    logic rd_root;
    logic set_full;
    logic set_empty;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] in_op;
    logic fill_zero;
    logic last_one;
    logic full;
    logic match;
    logic idx_left;
    logic pos_zero;
    logic moved;
    logic cur_lt_rd;
    logic left_ok;
    logic right_ok;
    logic best_child;
    logic out_free;
  } sts_t;

endpackage

[hdl/kmh_if.sv]
// Channel interfaces for the keyed min-heap counter: request, response and configuration.
// Depends on kmh_pkg for field widths.
interface kmh_req_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [kmh_pkg::KEY_IN_W-1:0] key_id;
  logic signed [kmh_pkg::CNT_W-1:0] value;
  modport source(output valid, op, key_id, value, input ready);
  modport sink(input valid, op, key_id, value, output ready);
endinterface

interface kmh_rsp_if #(parameter int CW = 9);
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [kmh_pkg::CNT_W-1:0] min_count;
  logic [CW-1:0] entry_count;
  modport source(output valid, status, min_count, entry_count, input ready);
  modport sink(input valid, status, min_count, entry_count, output ready);
endinterface

interface kmh_cfg_if;
  logic valid;
  logic ready;
  logic [kmh_pkg::CAP_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[hdl/kmh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module kmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not reading.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/kmh_datapath.sv]
// Datapath of the keyed min-heap counter: entry RAM, sift registers, fill level and result.
// Depends on kmh_pkg and kmh_ram; driven by kmh_ctrl through cmd_t and sts_t.
module kmh_datapath #(
  parameter int MAX_ENTRIES = 256,
  parameter int KEY_BITS = 64,
  parameter int CW = 9
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kmh_pkg::cmd_t                        cmd,
  output kmh_pkg::sts_t                        sts,
  input  logic [1:0]                           in_op,
  input  logic [kmh_pkg::KEY_IN_W-1:0]         in_key,
  input  logic [kmh_pkg::CNT_W-1:0]            in_value,
  input  logic                                 cfg_write,
  input  logic [kmh_pkg::CAP_W-1:0]            cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [kmh_pkg::CNT_W-1:0]            out_min,
  output logic [CW-1:0]                        out_count
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int XW = AW + 2;
  localparam int LW = (CW > kmh_pkg::CAP_W) ? CW : kmh_pkg::CAP_W;
  localparam int EW = KEY_BITS + kmh_pkg::CNT_W;
  localparam int NW = kmh_pkg::CNT_W;

  logic [kmh_pkg::CAP_W-1:0] capacity;
  logic [1:0]                op_q;
  logic [KEY_BITS-1:0]       key_q;
  logic [NW-1:0]             val_q;
  logic [1:0]                status_q;
  logic [CW-1:0]             fill;
  logic [CW-1:0]             idx;
  logic                      pend;
  logic [AW-1:0]             pend_idx;
  logic [AW-1:0]             pos;
  logic [AW-1:0]             start;
  logic [KEY_BITS-1:0]       cur_key;
  logic [NW-1:0]             cur_cnt;
  logic [KEY_BITS-1:0]       best_key;
  logic [NW-1:0]             best_cnt;
  logic [AW-1:0]             best_idx;
  logic                      best_child;

  logic                      ram_we;
  logic [EW-1:0]             ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [EW-1:0]             rd_data;
  logic [KEY_BITS-1:0]       rd_key;
  logic [NW-1:0]             rd_cnt;

  logic [AW-1:0]             parent;
  logic [XW-1:0]             left_x;
  logic [XW-1:0]             right_x;
  logic [XW-1:0]             fill_x;
  logic [LW-1:0]             cap_x;
  logic [LW-1:0]             max_x;
  logic [LW-1:0]             limit;
  logic                      rd_lt_cur;
  logic                      cur_lt_rd;
  logic                      rd_lt_best;

  assign rd_key = rd_data[EW-1:NW];
  assign rd_cnt = rd_data[NW-1:0];

  // Heap index arithmetic.
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign left_x  = XW'({pos, 1'b1});
  assign right_x = left_x + XW'(1);
  assign fill_x  = XW'(fill);

  // Insert limit is the smaller of the register and the store depth.
  assign cap_x = LW'(capacity);
  assign max_x = LW'(MAX_ENTRIES);
  assign limit = (cap_x < max_x) ? cap_x : max_x;

  // Signed count compares.
  assign rd_lt_cur  = $signed(rd_cnt) < $signed(cur_cnt);
  assign cur_lt_rd  = $signed(cur_cnt) < $signed(rd_cnt);
  assign rd_lt_best = $signed(rd_cnt) < $signed(best_cnt);

  // Status back to the controller.
  always_comb begin
    sts.in_op      = in_op;
    sts.fill_zero  = (fill == '0);
    sts.last_one   = (fill == CW'(1));
    sts.full       = (LW'(fill) >= limit);
    sts.match      = pend && (rd_key == key_q);
    sts.idx_left   = (idx < fill);
    sts.pos_zero   = (pos == '0);
    sts.moved      = (pos != start);
    sts.cur_lt_rd  = cur_lt_rd;
    sts.left_ok    = (left_x < fill_x);
    sts.right_ok   = (right_x < fill_x);
    sts.best_child = best_child;
    sts.out_free   = !out_valid || out_ready;
  end

  // RAM read address selection.
  always_comb begin
    ram_re = cmd.srch_issue | cmd.rd_parent | cmd.rd_left | cmd.rd_right |
             cmd.rd_last | cmd.rd_root;
    ram_raddr = '0;
    if (cmd.srch_issue) begin
      ram_raddr = idx[AW-1:0];
    end else if (cmd.rd_parent) begin
      ram_raddr = parent;
    end else if (cmd.rd_left) begin
      ram_raddr = left_x[AW-1:0];
    end else if (cmd.rd_right) begin
      ram_raddr = right_x[AW-1:0];
    end else if (cmd.rd_last) begin
      ram_raddr = AW'(fill - CW'(1));
    end
  end

  // Every write lands in the hole at the current position.
  always_comb begin
    ram_we = cmd.move_parent | cmd.write_best | cmd.write_cur;
    if (cmd.move_parent) begin
      ram_wdata = rd_data;
    end else if (cmd.write_best) begin
      ram_wdata = {best_key, best_cnt};
    end else begin
      ram_wdata = {cur_key, cur_cnt};
    end
  end

  kmh_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(pos),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // Control registers: capacity, fill level, search pipeline and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= kmh_pkg::CAP_W'(256);
      fill      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (cmd.take_new) begin
        fill <= fill + CW'(1);
      end else if (cmd.rm_load) begin
        fill <= fill - CW'(1);
      end
      pend <= cmd.srch_issue;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= in_op;
      key_q    <= in_key[KEY_BITS-1:0];
      val_q    <= in_value;
      status_q <= kmh_pkg::ST_OK;
    end
    if (cmd.set_full) begin
      status_q <= kmh_pkg::ST_FULL;
    end
    if (cmd.set_empty) begin
      status_q <= kmh_pkg::ST_EMPTY;
    end
    if (cmd.srch_start) begin
      idx <= '0;
    end else if (cmd.srch_issue) begin
      idx <= idx + CW'(1);
    end
    pend_idx <= idx[AW-1:0];

    // Load the moving entry.
    if (cmd.take_found) begin
      cur_key <= key_q;
      cur_cnt <= (op_q == kmh_pkg::OP_ADD) ? rd_cnt + val_q : val_q;
      pos     <= pend_idx;
      start   <= pend_idx;
    end else if (cmd.take_new) begin
      cur_key <= key_q;
      cur_cnt <= val_q;
      pos     <= fill[AW-1:0];
      start   <= fill[AW-1:0];
    end else if (cmd.rm_load) begin
      cur_key <= rd_key;
      cur_cnt <= rd_cnt;
      pos     <= '0;
      start   <= '0;
    end else if (cmd.move_parent) begin
      pos <= parent;
    end else if (cmd.write_best) begin
      pos <= best_idx;
    end

    // Pick the smallest of the entry and its children; ties keep the earlier one.
    if (cmd.eval_left) begin
      if (rd_lt_cur) begin
        best_key   <= rd_key;
        best_cnt   <= rd_cnt;
        best_idx   <= left_x[AW-1:0];
        best_child <= 1'b1;
      end else begin
        best_key   <= cur_key;
        best_cnt   <= cur_cnt;
        best_child <= 1'b0;
      end
    end else if (cmd.eval_right && rd_lt_best) begin
      best_key   <= rd_key;
      best_cnt   <= rd_cnt;
      best_idx   <= right_x[AW-1:0];
      best_child <= 1'b1;
    end

    // Result register.
    if (cmd.emit) begin
      out_status <= status_q;
      out_min    <= (fill == '0) ? '0 : rd_cnt;
      out_count  <= fill;
    end
  end

endmodule

[hdl/kmh_ctrl.sv]
// Controller of the keyed min-heap counter: sequences lookup, sift up, sift down and result.
// Depends on kmh_pkg; drives kmh_datapath through cmd_t and reads sts_t.
module kmh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kmh_pkg::sts_t sts,
  output kmh_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_UP     = 4'd2;
  localparam logic [3:0] S_UPC    = 4'd3;
  localparam logic [3:0] S_UPEND  = 4'd4;
  localparam logic [3:0] S_DOWN   = 4'd5;
  localparam logic [3:0] S_DL     = 4'd6;
  localparam logic [3:0] S_DR     = 4'd7;
  localparam logic [3:0] S_DDEC   = 4'd8;
  localparam logic [3:0] S_RMLD   = 4'd9;
  localparam logic [3:0] S_ROOT   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_op == kmh_pkg::OP_SET || sts.in_op == kmh_pkg::OP_ADD) begin
            cmd.srch_start = 1'b1;
            state_next = S_SEARCH;
          end else if (sts.in_op == kmh_pkg::OP_REMOVE) begin
            if (sts.fill_zero) begin
              cmd.set_empty = 1'b1;
              state_next = S_ROOT;
            end else begin
              cmd.rd_last = 1'b1;
              state_next = S_RMLD;
            end
          end else begin
            state_next = S_ROOT;
          end
        end
      end
      S_SEARCH: begin
        // One slot read issued per cycle, compared the cycle after.
        if (sts.match) begin
          cmd.take_found = 1'b1;
          state_next = S_UP;
        end else if (sts.idx_left) begin
          cmd.srch_issue = 1'b1;
        end else if (sts.full) begin
          cmd.set_full = 1'b1;
          state_next = S_ROOT;
        end else begin
          cmd.take_new = 1'b1;
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (sts.pos_zero) begin
          state_next = S_UPEND;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next = S_UPC;
        end
      end
      S_UPC: begin
        // The parent moves down only when the entry is strictly smaller.
        if (sts.cur_lt_rd) begin
          cmd.move_parent = 1'b1;
          state_next = S_UP;
        end else begin
          state_next = S_UPEND;
        end
      end
      S_UPEND: begin
        // An entry that rose is settled; otherwise try sinking it.
        if (sts.moved) begin
          cmd.write_cur = 1'b1;
          state_next = S_ROOT;
        end else begin
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        if (sts.left_ok) begin
          cmd.rd_left = 1'b1;
          state_next = S_DL;
        end else begin
          cmd.write_cur = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_DL: begin
        cmd.eval_left = 1'b1;
        if (sts.right_ok) begin
          cmd.rd_right = 1'b1;
          state_next = S_DR;
        end else begin
          state_next = S_DDEC;
        end
      end
      S_DR: begin
        cmd.eval_right = 1'b1;
        state_next = S_DDEC;
      end
      S_DDEC: begin
        if (sts.best_child) begin
          cmd.write_best = 1'b1;
          state_next = S_DOWN;
        end else begin
          cmd.write_cur = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_RMLD: begin
        cmd.rm_load = 1'b1;
        state_next = sts.last_one ? S_ROOT : S_DOWN;
      end
      S_ROOT: begin
        cmd.rd_root = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/keyed_min_heap_counter.sv]
// Keyed min-heap counter: one response per request, one request in flight at a time.
// Set and add scan the occupied slots one per cycle, then sift up or sift down; then the
// root is read and the response registered. Remove skips the scan. The entry RAM's single
// read port means the scan and the sifts read one slot at a time. Reset empties the heap
// and sets capacity to 256.
// Depends on kmh_pkg, kmh_if, kmh_ram, kmh_ctrl and kmh_datapath.
module keyed_min_heap_counter #(
  parameter int MAX_ENTRIES = 256,
  parameter int KEY_BITS = 64
) (
  input logic    clk,
  input logic    rst,
  kmh_req_if.sink req_ch,
  kmh_rsp_if.source rsp_ch,
  kmh_cfg_if.sink cfg_ch
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  kmh_pkg::cmd_t cmd;
  kmh_pkg::sts_t sts;

  // The capacity register takes a write in any cycle.
  assign cfg_ch.ready = 1'b1;

  kmh_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(req_ch.valid),
    .in_ready(req_ch.ready),
    .sts(sts),
    .cmd(cmd)
  );

  kmh_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .KEY_BITS(KEY_BITS),
    .CW(CW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .in_op(req_ch.op),
    .in_key(req_ch.key_id),
    .in_value(req_ch.value),
    .cfg_write(cfg_ch.valid),
    .cfg_data(cfg_ch.data),
    .out_ready(rsp_ch.ready),
    .out_valid(rsp_ch.valid),
    .out_status(rsp_ch.status),
    .out_min(rsp_ch.min_count),
    .out_count(rsp_ch.entry_count)
  );

endmodule
